[rtl/bssc_pkg.sv]
`default_nettype none
package bssc_pkg;

    localparam int MAX_VALUE   = 128;
    localparam int COUNT_W     = 30;
    localparam int ENTRY_W     = 8;
    localparam int LIMIT_W     = 8;
    // wide enough for MAX_VALUE + 1 and for any 8-bit entry or limit
    localparam int VAL_W       = ($clog2(MAX_VALUE + 2) > 8) ? $clog2(MAX_VALUE + 2) : 9;
    localparam int TREE_LVLS   = $clog2(MAX_VALUE);
    localparam int TREE_LEAVES = 1 << TREE_LVLS;
    localparam int LVL_CNT_W   = $clog2(TREE_LVLS + 1);

    localparam logic [COUNT_W-1:0] COUNT_MODULUS = COUNT_W'(1000000007);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(128);

    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic cell_upd;
        logic out_load;
    } t_ctrl_cmd;

    // sum of two residues, reduced once
    function automatic t_count mod_add2(input t_count a, input t_count b);
        logic [COUNT_W:0] s;
        logic [COUNT_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, COUNT_MODULUS};
        mod_add2 = (s >= {1'b0, COUNT_MODULUS}) ? d[COUNT_W-1:0] : s[COUNT_W-1:0];
    endfunction

    // sum of three residues, reduced by 0, p or 2p
    function automatic t_count mod_add3(input t_count a, input t_count b, input t_count c);
        logic [COUNT_W+1:0] s;
        logic [COUNT_W+1:0] p1;
        logic [COUNT_W+1:0] p2;
        logic [COUNT_W+1:0] d1;
        logic [COUNT_W+1:0] d2;
        s  = {2'b00, a} + {2'b00, b} + {2'b00, c};
        p1 = {2'b00, COUNT_MODULUS};
        p2 = {1'b0, COUNT_MODULUS, 1'b0};
        d1 = s - p1;
        d2 = s - p2;
        if (s >= p2) begin
            mod_add3 = d2[COUNT_W-1:0];
        end else if (s >= p1) begin
            mod_add3 = d1[COUNT_W-1:0];
        end else begin
            mod_add3 = s[COUNT_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

[rtl/bssc_in_if.sv]
`default_nettype none
interface bssc_in_if;
    logic                           valid;
    logic                           ready;
    logic [bssc_pkg::ENTRY_W-1:0]   entry_value;
    logic                           first_entry;

    modport source (output valid, output entry_value, output first_entry, input ready);
    modport sink   (input valid, input entry_value, input first_entry, output ready);
endinterface
`default_nettype wire

[rtl/bssc_out_if.sv]
`default_nettype none
interface bssc_out_if;
    logic                           valid;
    logic                           ready;
    logic [bssc_pkg::COUNT_W-1:0]   way_count;

    modport source (output valid, output way_count, input ready);
    modport sink   (input valid, input way_count, output ready);
endinterface
`default_nettype wire

[rtl/bssc_ctrl.sv]
`default_nettype none
module bssc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output bssc_pkg::t_ctrl_cmd o_cmd
);
    import bssc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [LVL_CNT_W-1:0]   r_lvl_cnt;
    logic                   r_out_valid;
    logic                   w_accept;
    logic                   w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign o_cmd.cell_upd = w_accept;
    assign o_cmd.out_load = (r_state == S_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a load in the same cycle keeps valid high
            if (r_out_valid && i_out_ready && !o_cmd.out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state   <= S_SUM;
                        r_lvl_cnt <= '0;
                    end
                end
                S_SUM: begin
                    // one adder-tree level settles per cycle
                    if (r_lvl_cnt == LVL_CNT_W'(TREE_LVLS - 1)) begin
                        r_state <= S_DONE;
                    end
                    r_lvl_cnt <= r_lvl_cnt + 1'b1;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/bssc_datapath.sv]
`default_nettype none
module bssc_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bssc_pkg::t_ctrl_cmd        i_cmd,
    input  wire logic [bssc_pkg::ENTRY_W-1:0] i_entry_value,
    input  wire logic                       i_first_entry,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [bssc_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    output logic [bssc_pkg::COUNT_W-1:0]    o_way_count
);
    import bssc_pkg::*;

    logic [LIMIT_W-1:0] r_value_limit;
    t_count             r_cell [MAX_VALUE];
    t_count             n_cell [MAX_VALUE];
    t_count             r_node [TREE_LEAVES-1];
    t_count             n_node [TREE_LEAVES-1];
    t_count             r_way_count;
    logic [VAL_W-1:0]   w_lim;
    logic [VAL_W-1:0]   w_entry;

    assign w_lim   = (VAL_W'(r_value_limit) < VAL_W'(MAX_VALUE)) ?
                     VAL_W'(r_value_limit) : VAL_W'(MAX_VALUE);
    assign w_entry = VAL_W'(i_entry_value);

    // per-value cell update, all cells in parallel
    for (genvar i = 0; i < MAX_VALUE; i++) begin : g_cell
        logic   w_allowed;
        t_count w_lo;
        t_count w_hi;
        assign w_allowed = (VAL_W'(i + 1) <= w_lim) &&
                           ((w_entry == '0) || (w_entry == VAL_W'(i + 1)));
        if (i > 0) begin : g_lo
            assign w_lo = r_cell[i-1];
        end else begin : g_no_lo
            assign w_lo = '0;
        end
        if (i < MAX_VALUE - 1) begin : g_hi
            // upper neighbor only counts when it is still in range
            assign w_hi = (VAL_W'(i + 2) <= w_lim) ? r_cell[i+1] : '0;
        end else begin : g_no_hi
            assign w_hi = '0;
        end
        always_comb begin
            if (!w_allowed) begin
                n_cell[i] = '0;
            end else if (i_first_entry) begin
                n_cell[i] = COUNT_W'(1);
            end else begin
                n_cell[i] = mod_add3(r_cell[i], w_lo, w_hi);
            end
        end
    end

    // registered binary sum tree, heap order, root at node 0
    for (genvar k = 0; k < TREE_LEAVES - 1; k++) begin : g_node
        t_count w_l;
        t_count w_r;
        if (2 * k + 1 >= TREE_LEAVES - 1) begin : g_leaf_l
            if (2 * k + 1 - (TREE_LEAVES - 1) < MAX_VALUE) begin : g_on
                assign w_l = r_cell[2 * k + 1 - (TREE_LEAVES - 1)];
            end else begin : g_pad
                assign w_l = '0;
            end
        end else begin : g_int_l
            assign w_l = r_node[2 * k + 1];
        end
        if (2 * k + 2 >= TREE_LEAVES - 1) begin : g_leaf_r
            if (2 * k + 2 - (TREE_LEAVES - 1) < MAX_VALUE) begin : g_on
                assign w_r = r_cell[2 * k + 2 - (TREE_LEAVES - 1)];
            end else begin : g_pad
                assign w_r = '0;
            end
        end else begin : g_int_r
            assign w_r = r_node[2 * k + 2];
        end
        assign n_node[k] = mod_add2(w_l, w_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_limit <= LIMIT_RESET;
            for (int i = 0; i < MAX_VALUE; i++) begin
                r_cell[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_value_limit <= i_cfg_wr_data;
            end
            if (i_cmd.cell_upd) begin
                for (int i = 0; i < MAX_VALUE; i++) begin
                    r_cell[i] <= n_cell[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TREE_LEAVES - 1; k++) begin
            r_node[k] <= n_node[k];
        end
        if (i_cmd.out_load) begin
            r_way_count <= r_node[0];
        end
    end

    assign o_way_count = r_way_count;
endmodule
`default_nettype wire

[rtl/bounded_step_sequence_counter_top.sv]
`default_nettype none
// Channel    Dir  Handshake      Word
// i_item     in   valid/ready    entry_value[7:0], first_entry
// o_result   out  valid/ready    way_count[29:0]
// i_cfg_*    in   write enable   value_limit[7:0]
//
// Each word passes through the parallel cell update, then through each level of
// the registered modular sum tree in turn, and finally through the load of the
// output register.
// Reset (synchronous, active low) clears all cells and sets the limit to 128.
// A new word is taken as soon as the previous sum has reached the output
// register; a stalled result holds only the final load.
module bounded_step_sequence_counter_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    bssc_in_if.sink                           i_item,
    bssc_out_if.source                        o_result,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [bssc_pkg::LIMIT_W-1:0] i_cfg_wr_data
);
    import bssc_pkg::*;

    t_ctrl_cmd w_cmd;

    bssc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_result.ready),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (w_cmd)
    );

    bssc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_entry_value (i_item.entry_value),
        .i_first_entry (i_item.first_entry),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_way_count   (o_result.way_count)
    );
endmodule
`default_nettype wire
